// ===== rtl/core/cdw_pkg.sv =====
// Shared constants, types and fixed-point helpers for the concentric disk warp.
// No dependencies; every module of the block imports this package.
package cdw_pkg;

  localparam int SEED_BITS     = 16;
  localparam int OUT_FRAC_BITS = 15;
  localparam int WF            = 30;                 // working fraction bits
  localparam int Q_W           = WF + 1;             // Q.30 values up to 1.0
  localparam int MAJ_W         = SEED_BITS + 1;      // |2x-1| scaled, up to 2^SEED_BITS
  localparam int REM_W         = MAJ_W + 1;
  localparam int OUT_W         = OUT_FRAC_BITS + 2;
  localparam int DIV_STAGES    = WF + 1;
  localparam int ROUND_SH      = SEED_BITS + WF - OUT_FRAC_BITS;
  localparam int SIN_STEPS     = 3;
  localparam int COS_STEPS     = 4;

  localparam logic [Q_W-1:0] ONE_Q       = {1'b1, {WF{1'b0}}};
  localparam logic [Q_W-1:0] PI_OVER_4_Q = Q_W'(843314857);

  typedef logic [1:0] quad_t;
  localparam quad_t QUAD_E = 2'd0;
  localparam quad_t QUAD_N = 2'd1;
  localparam quad_t QUAD_W = 2'd2;
  localparam quad_t QUAD_S = 2'd3;

  typedef struct packed {
    logic [MAJ_W-1:0] umaj;
    quad_t            quad;
    logic             neg;
  } side_t;

  // Reciprocal constants: ceil(2^(WF+l)/d), l = ceil(log2(d)); exact for WF-bit dividends
  localparam logic [Q_W-1:0] M_72 = Q_W'(((64'd1 << (WF + 7)) + 64'd71) / 64'd72);
  localparam logic [Q_W-1:0] M_90 = Q_W'(((64'd1 << (WF + 7)) + 64'd89) / 64'd90);
  localparam logic [Q_W-1:0] M_42 = Q_W'(((64'd1 << (WF + 6)) + 64'd41) / 64'd42);
  localparam logic [Q_W-1:0] M_56 = Q_W'(((64'd1 << (WF + 6)) + 64'd55) / 64'd56);
  localparam logic [Q_W-1:0] M_20 = Q_W'(((64'd1 << (WF + 5)) + 64'd19) / 64'd20);
  localparam logic [Q_W-1:0] M_30 = Q_W'(((64'd1 << (WF + 5)) + 64'd29) / 64'd30);
  localparam logic [Q_W-1:0] M_6  = Q_W'(((64'd1 << (WF + 3)) + 64'd5) / 64'd6);
  localparam logic [Q_W-1:0] M_12 = Q_W'(((64'd1 << (WF + 4)) + 64'd11) / 64'd12);
  localparam logic [Q_W-1:0] M_2  = Q_W'(((64'd1 << (WF + 1)) + 64'd1) / 64'd2);

  localparam int K_72 = WF + 7;
  localparam int K_90 = WF + 7;

  localparam logic [Q_W-1:0] SIN_M [SIN_STEPS] = '{M_42, M_20, M_6};
  localparam int             SIN_K [SIN_STEPS] = '{WF + 6, WF + 5, WF + 3};
  localparam logic [Q_W-1:0] COS_M [COS_STEPS] = '{M_56, M_30, M_12, M_2};
  localparam int             COS_K [COS_STEPS] = '{WF + 6, WF + 5, WF + 4, WF + 1};

  // Q.30 product, truncated
  function automatic logic [Q_W-1:0] mulq(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] prod;
    prod = {{Q_W{1'b0}}, a} * {{Q_W{1'b0}}, b};
    return Q_W'(prod >> WF);
  endfunction

  // Truncated division of a WF-bit value by a constant, via its reciprocal
  function automatic logic [WF-1:0] cdiv(input logic [WF-1:0] x, input logic [Q_W-1:0] m,
                                         input int k);
    logic [WF+Q_W-1:0] prod;
    prod = {{Q_W{1'b0}}, x} * {{WF{1'b0}}, m};
    return WF'(prod >> k);
  endfunction

endpackage

// ===== rtl/core/cdw_div.sv =====
// Pipelined restoring divider: ratio |minor|/major as Q.30, one quotient bit per stage.
// Depends on cdw_pkg.
module cdw_div import cdw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [MAJ_W-1:0]     in_um,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic [Q_W-1:0]       out_u,
  output side_t                out_side
);

  logic                 v_r    [DIV_STAGES];
  logic [REM_W-1:0]     rem_r  [DIV_STAGES];
  logic [Q_W-1:0]       q_r    [DIV_STAGES];
  side_t                side_r [DIV_STAGES];

  logic                 v_nxt    [DIV_STAGES];
  logic [REM_W-1:0]     rem_nxt  [DIV_STAGES];
  logic [Q_W-1:0]       q_nxt    [DIV_STAGES];
  side_t                side_nxt [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [Q_W-1:0]   q_in;
    side_t            side_in;
    logic             bit_q;

    if (i == 0) begin : g_first
      always_comb begin
        rem_in      = {1'b0, in_um};
        q_in        = '0;
        side_in     = in_side;
        v_nxt[i]    = in_valid;
      end
    end else begin : g_next
      always_comb begin
        rem_in      = {rem_r[i-1][REM_W-2:0], 1'b0};
        q_in        = q_r[i-1];
        side_in     = side_r[i-1];
        v_nxt[i]    = v_r[i-1];
      end
    end

    always_comb begin
      bit_q       = (rem_in >= {1'b0, side_in.umaj});
      rem_nxt[i]  = bit_q ? rem_in - {1'b0, side_in.umaj} : rem_in;
      q_nxt[i]    = {q_in[Q_W-2:0], bit_q};
      side_nxt[i] = side_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_nxt[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt[i];
        q_r[i]    <= q_nxt[i];
        side_r[i] <= side_nxt[i];
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_u     = q_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

// ===== rtl/core/cdw_trig.sv =====
// Angle and Horner-series pipeline: th = u*pi/4, then cos(th) and sin(th) in Q.30.
// Depends on cdw_pkg.
module cdw_trig import cdw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [Q_W-1:0]   in_u,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_cos,
  output logic [Q_W-1:0]   out_sin,
  output side_t            out_side
);

  // th, t2, series start, multiply/divide pair per Horner step, final sin product
  localparam int NS = 3 + 2 * COS_STEPS + 1;

  logic           v_r   [NS];
  logic [Q_W-1:0] th_r  [NS];
  logic [Q_W-1:0] t2_r  [NS];
  logic [Q_W-1:0] p_r   [NS];
  logic [Q_W-1:0] q_r   [NS];
  side_t          sd_r  [NS];

  logic           v_nxt  [NS];
  logic [Q_W-1:0] th_nxt [NS];
  logic [Q_W-1:0] t2_nxt [NS];
  logic [Q_W-1:0] p_nxt  [NS];
  logic [Q_W-1:0] q_nxt  [NS];
  side_t          sd_nxt [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    if (j == 0) begin : g_angle
      logic [Q_W-1:0] u_cl;
      always_comb begin
        u_cl      = (in_u > ONE_Q) ? ONE_Q : in_u;
        v_nxt[j]  = in_valid;
        sd_nxt[j] = in_side;
        th_nxt[j] = mulq(u_cl, PI_OVER_4_Q);
        t2_nxt[j] = '0;
        p_nxt[j]  = '0;
        q_nxt[j]  = '0;
      end
    end else begin : g_later
      always_comb begin
        v_nxt[j]  = v_r[j-1];
        sd_nxt[j] = sd_r[j-1];
        th_nxt[j] = th_r[j-1];
        t2_nxt[j] = t2_r[j-1];
        p_nxt[j]  = p_r[j-1];
        q_nxt[j]  = q_r[j-1];
        if (j == 1) begin
          t2_nxt[j] = mulq(th_r[j-1], th_r[j-1]);
        end else if (j == 2) begin
          p_nxt[j] = ONE_Q - {1'b0, cdiv(t2_r[j-1][WF-1:0], M_72, K_72)};
          q_nxt[j] = ONE_Q - {1'b0, cdiv(t2_r[j-1][WF-1:0], M_90, K_90)};
        end else if (j == NS - 1) begin
          p_nxt[j] = mulq(th_r[j-1], p_r[j-1]);
        end else if (((j - 3) % 2) == 0) begin
          // multiply by t2
          if (((j - 3) / 2) < SIN_STEPS) begin
            p_nxt[j] = mulq(t2_r[j-1], p_r[j-1]);
          end
          q_nxt[j] = mulq(t2_r[j-1], q_r[j-1]);
        end else begin
          // divide by the series constant and subtract from one
          if (((j - 3) / 2) < SIN_STEPS) begin
            p_nxt[j] = ONE_Q - {1'b0, cdiv(p_r[j-1][WF-1:0],
                                           SIN_M[((j - 3) / 2) % SIN_STEPS],
                                           SIN_K[((j - 3) / 2) % SIN_STEPS])};
          end
          q_nxt[j] = ONE_Q - {1'b0, cdiv(q_r[j-1][WF-1:0],
                                         COS_M[(j - 3) / 2], COS_K[(j - 3) / 2])};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_nxt[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        th_r[j] <= th_nxt[j];
        t2_r[j] <= t2_nxt[j];
        p_r[j]  <= p_nxt[j];
        q_r[j]  <= q_nxt[j];
        sd_r[j] <= sd_nxt[j];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_cos   = q_r[NS-1];
  assign out_sin   = p_r[NS-1];
  assign out_side  = sd_r[NS-1];

endmodule

// ===== rtl/core/concentric_disk_warp.sv =====
// Top level of the concentric square-to-disk warp: wedge select, divider, trig, output.
// Depends on cdw_pkg, cdw_div and cdw_trig.
//
//   channel | direction | ports                         | meaning
//   in_     | request   | in_valid, in_stall, seed x/y  | two unsigned seeds in [0,1)
//   out_    | result    | out_valid, out_stall, disk x/y| signed Q1.15 point on disk
//
// One request enters per clock unless a result is held; the path runs through the wedge
// register, divider (one quotient bit per stage), Horner series, scale and output stages.
// Reset clears the valid bits only; payload registers hold garbage until filled.
// A held result stalls every stage at once (in_stall follows out_stall while the
// output register is full), so no request is dropped or duplicated.
module concentric_disk_warp import cdw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SEED_BITS-1:0]    in_seed_x,
  input  logic [SEED_BITS-1:0]    in_seed_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_disk_x,
  output logic signed [OUT_W-1:0] out_disk_y
);

  localparam int A_W = SEED_BITS + 2;
  localparam int PROD_W = MAJ_W + Q_W;

  logic en;

  // Wedge select stage
  logic signed [A_W-1:0] a, b, major, minor;
  logic signed [A_W:0]   sum_ab;
  logic                  p_valid_r;
  side_t                 p_side_r, p_side_nxt;
  logic [MAJ_W-1:0]      p_um_r, p_um_nxt;

  // Divider and trig
  logic                  d_valid;
  logic [Q_W-1:0]        d_u;
  side_t                 d_side;
  logic                  t_valid;
  logic [Q_W-1:0]        t_cos, t_sin;
  side_t                 t_side;

  // Scale stage
  logic                  r_valid_r;
  logic [OUT_W-1:0]      r_lx_r, r_ly_r, r_lx_nxt, r_ly_nxt;
  side_t                 r_side_r;
  logic [PROD_W-1:0]     prod_x, prod_y;

  // Output stage
  logic                  o_valid_r;
  logic [OUT_W-1:0]      o_x_r, o_y_r, o_x_nxt, o_y_nxt, ly_s;

  // Advance all stages unless a finished result is held
  assign en       = !(o_valid_r && out_stall);
  assign in_stall = !en;

  always_comb begin
    a      = $signed({1'b0, in_seed_x, 1'b0}) - $signed(A_W'(1) << SEED_BITS);
    b      = $signed({1'b0, in_seed_y, 1'b0}) - $signed(A_W'(1) << SEED_BITS);
    sum_ab = {a[A_W-1], a} + {b[A_W-1], b};
    p_side_nxt = '0;
    major  = '0;
    minor  = '0;
    if (sum_ab > 0) begin
      if (a > b) begin
        p_side_nxt.quad = QUAD_E;
        major = a;
        minor = b;
        p_side_nxt.neg = b < 0;
      end else begin
        p_side_nxt.quad = QUAD_N;
        major = b;
        minor = a;
        p_side_nxt.neg = a > 0;
      end
    end else begin
      if (a < b) begin
        p_side_nxt.quad = QUAD_W;
        major = -a;
        minor = b;
        p_side_nxt.neg = b > 0;
      end else begin
        p_side_nxt.quad = QUAD_S;
        major = -b;
        minor = a;
        p_side_nxt.neg = a < 0;
      end
    end
    p_side_nxt.umaj = major[MAJ_W-1:0];
    p_um_nxt        = minor[A_W-1] ? MAJ_W'(-minor) : minor[MAJ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      r_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= in_valid;
      r_valid_r <= t_valid;
      o_valid_r <= r_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_side_r <= p_side_nxt;
      p_um_r   <= p_um_nxt;
      r_lx_r   <= r_lx_nxt;
      r_ly_r   <= r_ly_nxt;
      r_side_r <= t_side;
      o_x_r    <= o_x_nxt;
      o_y_r    <= o_y_nxt;
    end
  end

  cdw_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_valid_r),
    .in_um     (p_um_r),
    .in_side   (p_side_r),
    .out_valid (d_valid),
    .out_u     (d_u),
    .out_side  (d_side)
  );

  cdw_trig u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .in_u      (d_u),
    .in_side   (d_side),
    .out_valid (t_valid),
    .out_cos   (t_cos),
    .out_sin   (t_sin),
    .out_side  (t_side)
  );

  // Scale r*trig down to the output grid, rounding half up on the magnitude
  always_comb begin
    prod_x   = {{Q_W{1'b0}}, t_side.umaj} * {{MAJ_W{1'b0}}, t_cos};
    prod_y   = {{Q_W{1'b0}}, t_side.umaj} * {{MAJ_W{1'b0}}, t_sin};
    r_lx_nxt = OUT_W'((prod_x + (PROD_W'(1) << (ROUND_SH - 1))) >> ROUND_SH);
    r_ly_nxt = OUT_W'((prod_y + (PROD_W'(1) << (ROUND_SH - 1))) >> ROUND_SH);
  end

  // Apply the minor-axis sign, then rotate by the wedge's quarter turns
  always_comb begin
    ly_s = r_side_r.neg ? -r_ly_r : r_ly_r;
    unique case (r_side_r.quad)
      QUAD_E: begin
        o_x_nxt = r_lx_r;
        o_y_nxt = ly_s;
      end
      QUAD_N: begin
        o_x_nxt = -ly_s;
        o_y_nxt = r_lx_r;
      end
      QUAD_W: begin
        o_x_nxt = -r_lx_r;
        o_y_nxt = -ly_s;
      end
      default: begin
        o_x_nxt = ly_s;
        o_y_nxt = -r_lx_r;
      end
    endcase
  end

  assign out_valid  = o_valid_r;
  assign out_disk_x = $signed(o_x_r);
  assign out_disk_y = $signed(o_y_r);

  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    r_valid_r |-> (r_lx_r <= (OUT_W'(1) << OUT_FRAC_BITS)) &&
                  (r_ly_r <= (OUT_W'(1) << OUT_FRAC_BITS)))
    else $error("scaled magnitude exceeds unity");

  a_centre_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (r_valid_r && r_side_r.umaj == '0) |-> (r_lx_r == '0) && (r_ly_r == '0))
    else $error("centre point gave a non-zero result");

  a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (d_valid && d_side.umaj != '0) |-> (d_u <= ONE_Q))
    else $error("divider ratio above one");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && out_stall) |=> $stable(r_valid_r) && $stable(p_valid_r) && $stable(t_valid))
    else $error("pipeline moved while the output was held");

endmodule
